/* design/bimt_pkg.sv */
// Shared types and constants for the branch interval membership table.
// No dependencies; used by every module of the block.
package bimt_pkg;

  localparam int MAX_INTERVALS_DEF = 64;
  localparam int SEQ_BITS_DEF      = 62;

  localparam int ACTION_W    = 2;
  localparam int BRANCH_W    = 15;
  localparam int SEQ_FIELD_W = 62;
  localparam int STATUS_W    = 2;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [ACTION_W-1:0] ACT_ADD   = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_QUERY = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd2;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  // Work kinds decided by the front end
  typedef enum logic [2:0] {
    OP_ADD,
    OP_ADD_BAD,
    OP_QUERY,
    OP_CLEAR,
    OP_NOP
  } op_t;

  // seq_a: upper bound on an add; seq_b: lower bound on an add, sequence on a query
  typedef struct packed {
    op_t                    op;
    logic [BRANCH_W-1:0]    branch;
    logic [SEQ_FIELD_W-1:0] seq_a;
    logic [SEQ_FIELD_W-1:0] seq_b;
  } cmd_t;

  typedef enum logic [0:0] {
    BK_IDLE,
    BK_SCAN
  } back_state_t;

endpackage

/* design/bimt_front.sv */
// Front end: takes command beats, checks intervals and classifies the work.
// Depends on bimt_pkg.
module bimt_front #(
  parameter int SEQ_BITS = bimt_pkg::SEQ_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [bimt_pkg::ACTION_W-1:0]    in_action,
  input  logic [bimt_pkg::BRANCH_W-1:0]    in_item_branch,
  input  logic [bimt_pkg::SEQ_FIELD_W-1:0] in_upper_seq,
  input  logic [bimt_pkg::SEQ_FIELD_W-1:0] in_lower_seq,
  input  logic [bimt_pkg::SEQ_FIELD_W-1:0] in_query_seq,
  input  logic                             q_full,
  output logic                             q_push,
  output bimt_pkg::cmd_t                   q_cmd
);

  logic                             hold_r, hold_nxt;
  logic [bimt_pkg::ACTION_W-1:0]    act_r;
  logic [bimt_pkg::BRANCH_W-1:0]    branch_r;
  logic [bimt_pkg::SEQ_FIELD_W-1:0] upper_r;
  logic [bimt_pkg::SEQ_FIELD_W-1:0] lower_r;
  logic [bimt_pkg::SEQ_FIELD_W-1:0] qseq_r;

  logic                accept;
  logic [SEQ_BITS-1:0] upper_m, lower_m, qseq_m;
  logic                bad_interval;

  assign busy     = hold_r & q_full;
  assign accept   = start & ~busy;
  assign q_push   = hold_r & ~q_full;
  assign hold_nxt = accept | (hold_r & ~q_push);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r <= 1'b0;
    end else begin
      hold_r <= hold_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      act_r    <= in_action;
      branch_r <= in_item_branch;
      upper_r  <= in_upper_seq;
      lower_r  <= in_lower_seq;
      qseq_r   <= in_query_seq;
    end
  end

  assign upper_m = upper_r[SEQ_BITS-1:0];
  assign lower_m = lower_r[SEQ_BITS-1:0];
  assign qseq_m  = qseq_r[SEQ_BITS-1:0];

  assign bad_interval = (upper_m == '0) | (lower_m == '0) | (upper_m <= lower_m);

  always_comb begin
    q_cmd.branch = branch_r;
    q_cmd.seq_a  = bimt_pkg::SEQ_FIELD_W'(upper_m);
    q_cmd.seq_b  = bimt_pkg::SEQ_FIELD_W'(lower_m);
    unique case (act_r)
      bimt_pkg::ACT_ADD: begin
        q_cmd.op = bad_interval ? bimt_pkg::OP_ADD_BAD : bimt_pkg::OP_ADD;
      end
      bimt_pkg::ACT_QUERY: begin
        q_cmd.op    = bimt_pkg::OP_QUERY;
        q_cmd.seq_b = bimt_pkg::SEQ_FIELD_W'(qseq_m);
      end
      bimt_pkg::ACT_CLEAR: begin
        q_cmd.op = bimt_pkg::OP_CLEAR;
      end
      default: begin
        q_cmd.op = bimt_pkg::OP_NOP;
      end
    endcase
  end

endmodule

/* design/bimt_queue.sv */
// Short command queue between front and back ends.
// Depends on bimt_pkg.
module bimt_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  bimt_pkg::cmd_t push_cmd,
  input  logic           pop,
  output bimt_pkg::cmd_t head_cmd,
  output logic           full,
  output logic           empty
);

  localparam int DEPTH = bimt_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  bimt_pkg::cmd_t   slot_r [DEPTH];
  logic [PTR_W-1:0] wptr_r, wptr_nxt;
  logic [PTR_W-1:0] rptr_r, rptr_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic             do_push, do_pop;

  assign full     = (fill_r == CNT_W'(DEPTH));
  assign empty    = (fill_r == '0);
  assign do_push  = push & ~full;
  assign do_pop   = pop & ~empty;
  assign head_cmd = slot_r[rptr_r];

  // depth is a power of two, so pointers wrap on their own
  assign wptr_nxt = do_push ? wptr_r + PTR_W'(1) : wptr_r;
  assign rptr_nxt = do_pop  ? rptr_r + PTR_W'(1) : rptr_r;

  always_comb begin
    fill_nxt = fill_r;
    if (do_push && !do_pop) begin
      fill_nxt = fill_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      fill_nxt = fill_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      fill_r <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wptr_r] <= push_cmd;
    end
  end

endmodule

/* design/bimt_back.sv */
// Back end: interval store, add/clear execution and the query scan.
// Depends on bimt_pkg.
module bimt_back #(
  parameter int MAX_INTERVALS = bimt_pkg::MAX_INTERVALS_DEF,
  parameter int SEQ_BITS      = bimt_pkg::SEQ_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_empty,
  input  bimt_pkg::cmd_t                q_cmd,
  output logic                          q_pop,
  output logic                          out_valid,
  output logic [bimt_pkg::STATUS_W-1:0] out_status,
  output logic                          out_rolled_back
);

  localparam int IDX_W = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
  localparam int CNT_W = $clog2(MAX_INTERVALS + 1);
  localparam int MEM_W = bimt_pkg::BRANCH_W + 2 * SEQ_BITS;

  bimt_pkg::back_state_t state_r, state_nxt;

  logic [CNT_W-1:0]              cnt_r, cnt_nxt;
  logic [CNT_W-1:0]              idx_r, idx_nxt;
  logic                          pend_r, pend_nxt;
  logic                          hit_r, hit_nxt;
  logic [bimt_pkg::BRANCH_W-1:0] qbranch_r, qbranch_nxt;
  logic [SEQ_BITS-1:0]           qseq_r, qseq_nxt;

  logic                          ov_r, ov_nxt;
  bimt_pkg::status_t             ost_r, ost_nxt;
  logic                          orb_r, orb_nxt;

  logic [MEM_W-1:0]              mem [MAX_INTERVALS];
  logic [MEM_W-1:0]              rdata_r;
  logic [MEM_W-1:0]              wdata;
  logic                          mem_we;

  logic [bimt_pkg::BRANCH_W-1:0] rd_branch;
  logic [SEQ_BITS-1:0]           rd_upper, rd_lower;
  logic                          rd_match;
  logic                          issue;
  logic                          at_full;

  assign wdata = {q_cmd.branch, q_cmd.seq_a[SEQ_BITS-1:0], q_cmd.seq_b[SEQ_BITS-1:0]};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[cnt_r[IDX_W-1:0]] <= wdata;
    end
    rdata_r <= mem[idx_r[IDX_W-1:0]];
  end

  assign rd_branch = rdata_r[MEM_W-1 -: bimt_pkg::BRANCH_W];
  assign rd_upper  = rdata_r[2*SEQ_BITS-1 -: SEQ_BITS];
  assign rd_lower  = rdata_r[SEQ_BITS-1:0];
  assign rd_match  = ((rd_branch == '0) | (rd_branch == qbranch_r)) &
                     (rd_lower < qseq_r) & (qseq_r <= rd_upper);

  assign issue   = (idx_r != cnt_r);
  assign at_full = (cnt_r == CNT_W'(MAX_INTERVALS));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bimt_pkg::BK_IDLE: begin
        if (!q_empty && q_cmd.op == bimt_pkg::OP_QUERY && cnt_r != '0) begin
          state_nxt = bimt_pkg::BK_SCAN;
        end
      end
      bimt_pkg::BK_SCAN: begin
        if (!issue && !pend_r) begin
          state_nxt = bimt_pkg::BK_IDLE;
        end
      end
      default: state_nxt = bimt_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop       = 1'b0;
    mem_we      = 1'b0;
    cnt_nxt     = cnt_r;
    idx_nxt     = idx_r;
    pend_nxt    = 1'b0;
    hit_nxt     = hit_r;
    qbranch_nxt = qbranch_r;
    qseq_nxt    = qseq_r;
    ov_nxt      = 1'b0;
    ost_nxt     = bimt_pkg::ST_OK;
    orb_nxt     = 1'b0;
    unique case (state_r)
      bimt_pkg::BK_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          unique case (q_cmd.op)
            bimt_pkg::OP_ADD: begin
              ov_nxt = 1'b1;
              if (at_full) begin
                ost_nxt = bimt_pkg::ST_FULL;
              end else begin
                mem_we  = 1'b1;
                cnt_nxt = cnt_r + CNT_W'(1);
              end
            end
            bimt_pkg::OP_ADD_BAD: begin
              ov_nxt  = 1'b1;
              ost_nxt = bimt_pkg::ST_INVALID;
            end
            bimt_pkg::OP_QUERY: begin
              // empty table answers at once
              if (cnt_r == '0) begin
                ov_nxt = 1'b1;
              end else begin
                idx_nxt     = '0;
                hit_nxt     = 1'b0;
                qbranch_nxt = q_cmd.branch;
                qseq_nxt    = q_cmd.seq_b[SEQ_BITS-1:0];
              end
            end
            bimt_pkg::OP_CLEAR: begin
              ov_nxt  = 1'b1;
              cnt_nxt = '0;
            end
            default: begin
              ov_nxt = 1'b1;
            end
          endcase
        end
      end
      bimt_pkg::BK_SCAN: begin
        // one read issued per cycle, checked in the next cycle
        if (issue) begin
          idx_nxt  = idx_r + CNT_W'(1);
          pend_nxt = 1'b1;
        end
        if (pend_r && rd_match) begin
          hit_nxt = 1'b1;
        end
        if (!issue && !pend_r) begin
          ov_nxt  = 1'b1;
          orb_nxt = hit_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bimt_pkg::BK_IDLE;
      cnt_r   <= '0;
      pend_r  <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      pend_r  <= pend_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r     <= idx_nxt;
    hit_r     <= hit_nxt;
    qbranch_r <= qbranch_nxt;
    qseq_r    <= qseq_nxt;
    ost_r     <= ost_nxt;
    orb_r     <= orb_nxt;
  end

  assign out_valid       = ov_r;
  assign out_status      = ost_r;
  assign out_rolled_back = orb_r;

endmodule

/* design/branch_interval_membership_table.sv */
// Top level of the branch interval membership table.
// Depends on bimt_pkg, bimt_front, bimt_queue and bimt_back.
//
//  channel | handshake         | beat taken when   | fields
//  --------+-------------------+-------------------+------------------------------------
//  in_     | start / busy      | start && !busy    | action, item_branch, upper/lower/query_seq
//  out_    | out_valid strobe  | every strobe      | status, rolled_back
//
// Add, clear and unused codes pass the front register and the command queue and are
// answered by the back end from its idle state; a query with entries stored scans the
// interval memory one read per cycle, up to MAX_INTERVALS entries, before it answers.
// Reset empties the table at once; no clearing pass is needed.
// busy rises only when the command queue and the front register are both full;
// the receiver cannot stall, one strobe per beat.
module branch_interval_membership_table #(
  parameter int MAX_INTERVALS = bimt_pkg::MAX_INTERVALS_DEF,
  parameter int SEQ_BITS      = bimt_pkg::SEQ_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [bimt_pkg::ACTION_W-1:0]    in_action,
  input  logic [bimt_pkg::BRANCH_W-1:0]    in_item_branch,
  input  logic [bimt_pkg::SEQ_FIELD_W-1:0] in_upper_seq,
  input  logic [bimt_pkg::SEQ_FIELD_W-1:0] in_lower_seq,
  input  logic [bimt_pkg::SEQ_FIELD_W-1:0] in_query_seq,
  output logic                             out_valid,
  output logic [bimt_pkg::STATUS_W-1:0]    out_status,
  output logic                             out_rolled_back
);

  bimt_pkg::cmd_t front_cmd;
  bimt_pkg::cmd_t head_cmd;
  logic           q_push, q_pop, q_full, q_empty;

  bimt_front #(
    .SEQ_BITS (SEQ_BITS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_action      (in_action),
    .in_item_branch (in_item_branch),
    .in_upper_seq   (in_upper_seq),
    .in_lower_seq   (in_lower_seq),
    .in_query_seq   (in_query_seq),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_cmd          (front_cmd)
  );

  bimt_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (front_cmd),
    .pop      (q_pop),
    .head_cmd (head_cmd),
    .full     (q_full),
    .empty    (q_empty)
  );

  bimt_back #(
    .MAX_INTERVALS (MAX_INTERVALS),
    .SEQ_BITS      (SEQ_BITS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .q_cmd           (head_cmd),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_rolled_back (out_rolled_back)
  );

endmodule

/* dv/branch_interval_membership_table_tb.sv */
// Testbench for branch_interval_membership_table: drives add, query, clear and spare commands
// and checks every result beat against a shadow copy of the interval table.
// Depends on bimt_pkg and the design files only.
module branch_interval_membership_table_tb;

  localparam int ACTION_W    = bimt_pkg::ACTION_W;
  localparam int BRANCH_W    = bimt_pkg::BRANCH_W;
  localparam int SEQ_FIELD_W = bimt_pkg::SEQ_FIELD_W;
  localparam int STATUS_W    = bimt_pkg::STATUS_W;

  localparam int TABLE_DEPTH = bimt_pkg::MAX_INTERVALS_DEF;
  localparam int DRAIN_CYCLES = TABLE_DEPTH + 20;
  localparam logic [ACTION_W-1:0] ACT_SPARE = 2'd3;
  localparam logic [SEQ_FIELD_W-1:0] SEQ_MAX = '1;
  localparam logic [BRANCH_W-1:0] BRANCH_MAX = '1;

  typedef struct packed {
    bimt_pkg::status_t status;
    logic              rolled_back;
  } answer_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   start = 1'b0;
  logic                   busy;
  logic [ACTION_W-1:0]    in_action = bimt_pkg::ACT_ADD;
  logic [BRANCH_W-1:0]    in_item_branch = '0;
  logic [SEQ_FIELD_W-1:0] in_upper_seq = '0;
  logic [SEQ_FIELD_W-1:0] in_lower_seq = '0;
  logic [SEQ_FIELD_W-1:0] in_query_seq = '0;
  logic                   out_valid;
  logic [STATUS_W-1:0]    out_status;
  logic                   out_rolled_back;

  // shadow of the interval table
  logic [BRANCH_W-1:0]    shadow_branch [TABLE_DEPTH];
  logic [SEQ_FIELD_W-1:0] shadow_upper [TABLE_DEPTH];
  logic [SEQ_FIELD_W-1:0] shadow_lower [TABLE_DEPTH];
  int                     shadow_count = 0;

  answer_t pending_answers [$];
  int      mismatch_count = 0;
  bit      no_gaps = 1'b0;

  always #2 clk = ~clk;

  branch_interval_membership_table DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_action       (in_action),
    .in_item_branch  (in_item_branch),
    .in_upper_seq    (in_upper_seq),
    .in_lower_seq    (in_lower_seq),
    .in_query_seq    (in_query_seq),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_rolled_back (out_rolled_back)
  );

  // Sequence width equals the field width, so no reduction is needed.
  function automatic answer_t apply_to_shadow(input logic [ACTION_W-1:0] act,
                                              input logic [BRANCH_W-1:0] br,
                                              input logic [SEQ_FIELD_W-1:0] up,
                                              input logic [SEQ_FIELD_W-1:0] lo,
                                              input logic [SEQ_FIELD_W-1:0] qs);
    answer_t ans;
    ans.status = bimt_pkg::ST_OK;
    ans.rolled_back = 1'b0;
    case (act)
      bimt_pkg::ACT_ADD: begin
        if (up == '0 || lo == '0 || up <= lo) begin
          ans.status = bimt_pkg::ST_INVALID;
        end else if (shadow_count >= TABLE_DEPTH) begin
          ans.status = bimt_pkg::ST_FULL;
        end else begin
          shadow_branch[shadow_count] = br;
          shadow_upper[shadow_count] = up;
          shadow_lower[shadow_count] = lo;
          shadow_count++;
        end
      end
      bimt_pkg::ACT_QUERY: begin
        for (int i = 0; i < shadow_count; i++) begin
          if ((shadow_branch[i] == '0 || shadow_branch[i] == br) &&
              shadow_lower[i] < qs && qs <= shadow_upper[i])
            ans.rolled_back = 1'b1;
        end
      end
      bimt_pkg::ACT_CLEAR: shadow_count = 0;
      default: ;
    endcase
    return ans;
  endfunction

  function automatic logic [SEQ_FIELD_W-1:0] rand_seq();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[SEQ_FIELD_W-1:0];
  endfunction

  function automatic logic [BRANCH_W-1:0] pick_branch();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return '0;
    if (r < 70) return BRANCH_W'($urandom_range(1, 3));
    if (r < 80) return BRANCH_MAX;
    return BRANCH_W'($urandom);
  endfunction

  function automatic int pick_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic note_mismatch(input string what, input logic [63:0] exp_v,
                               input logic [63:0] got_v);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("MISMATCH %s: expected %0d, got %0d at %0t", what, exp_v, got_v, $time);
  endtask

  // One beat; start stays high on return unless a gap follows.
  task automatic send_item(input logic [ACTION_W-1:0] act, input logic [BRANCH_W-1:0] br,
                           input logic [SEQ_FIELD_W-1:0] up, input logic [SEQ_FIELD_W-1:0] lo,
                           input logic [SEQ_FIELD_W-1:0] qs);
    int      gap;
    answer_t ans;
    start <= 1'b1;
    in_action <= act;
    in_item_branch <= br;
    in_upper_seq <= up;
    in_lower_seq <= lo;
    in_query_seq <= qs;
    do @(posedge clk); while (busy);
    ans = apply_to_shadow(act, br, up, lo, qs);
    pending_answers.insert(pending_answers.size(), ans);
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) begin
        in_action <= ACTION_W'($urandom);
        in_item_branch <= BRANCH_W'($urandom);
        in_upper_seq <= rand_seq();
        in_lower_seq <= rand_seq();
        in_query_seq <= rand_seq();
        @(posedge clk);
      end
    end
  endtask

  task automatic add_interval(input logic [BRANCH_W-1:0] br, input logic [SEQ_FIELD_W-1:0] lo,
                              input logic [SEQ_FIELD_W-1:0] up);
    send_item(bimt_pkg::ACT_ADD, br, up, lo, rand_seq());
  endtask

  task automatic ask_rollback(input logic [BRANCH_W-1:0] br, input logic [SEQ_FIELD_W-1:0] qs);
    send_item(bimt_pkg::ACT_QUERY, br, rand_seq(), rand_seq(), qs);
  endtask

  task automatic clear_table();
    send_item(bimt_pkg::ACT_CLEAR, BRANCH_W'($urandom), rand_seq(), rand_seq(), rand_seq());
  endtask

  // Well-formed interval: 0 < lo < up, spans from tiny to huge
  task automatic random_interval(output logic [SEQ_FIELD_W-1:0] lo,
                                 output logic [SEQ_FIELD_W-1:0] up);
    logic [SEQ_FIELD_W-1:0] span;
    logic [SEQ_FIELD_W:0]   sum;
    lo = rand_seq() >> $urandom_range(0, SEQ_FIELD_W - 1);
    span = rand_seq() >> $urandom_range(0, SEQ_FIELD_W - 1);
    if (lo == '0) lo = 1;
    if (lo == SEQ_MAX) lo = SEQ_MAX - 1;
    if (span == '0) span = 1;
    sum = {1'b0, lo} + {1'b0, span};
    up = (sum > {1'b0, SEQ_MAX}) ? SEQ_MAX : sum[SEQ_FIELD_W-1:0];
  endtask

  // Query aimed at the edges of a stored interval, or anywhere
  task automatic aimed_query();
    int k;
    logic [SEQ_FIELD_W-1:0] qs;
    logic [BRANCH_W-1:0]    br;
    if (shadow_count == 0 || $urandom_range(0, 9) < 3) begin
      ask_rollback(pick_branch(), rand_seq());
    end else begin
      k = $urandom_range(0, shadow_count - 1);
      case ($urandom_range(0, 4))
        0: qs = shadow_lower[k];
        1: qs = shadow_lower[k] + 1;
        2: qs = shadow_upper[k];
        3: qs = shadow_upper[k] + 1;
        default: qs = shadow_lower[k] + ((shadow_upper[k] - shadow_lower[k]) >> 1);
      endcase
      br = ($urandom_range(0, 1) == 0) ? shadow_branch[k] : pick_branch();
      ask_rollback(br, qs);
    end
  endtask

  task automatic test_empty_and_invalid();
    ask_rollback('0, 5);
    ask_rollback(BRANCH_MAX, SEQ_MAX);
    add_interval(1, 5, '0);
    add_interval(1, '0, 5);
    add_interval(2, 77, 77);
    add_interval(3, 20, 10);
    add_interval(BRANCH_MAX, SEQ_MAX, SEQ_MAX);
    send_item(ACT_SPARE, BRANCH_MAX, SEQ_MAX, SEQ_MAX, SEQ_MAX);
    clear_table();
  endtask

  task automatic test_interval_bounds();
    add_interval(5, 100, 200);
    add_interval('0, SEQ_MAX - 10, SEQ_MAX);
    add_interval(BRANCH_MAX, 1, 2);
    ask_rollback(5, 100);
    ask_rollback(5, 101);
    ask_rollback(5, 200);
    ask_rollback(5, 201);
    ask_rollback(6, 150);
    ask_rollback('0, 150);
    ask_rollback(123, SEQ_MAX);
    ask_rollback(123, SEQ_MAX - 10);
    ask_rollback(BRANCH_MAX, 2);
    ask_rollback(BRANCH_MAX, 1);
    clear_table();
    ask_rollback(5, 150);
  endtask

  task automatic test_fill_to_capacity();
    logic [SEQ_FIELD_W-1:0] lo, up;
    clear_table();
    repeat (TABLE_DEPTH) begin
      random_interval(lo, up);
      add_interval(pick_branch(), lo, up);
    end
    random_interval(lo, up);
    add_interval(pick_branch(), lo, up);
    // invalid takes precedence over full
    add_interval(pick_branch(), up, lo);
    ask_rollback(shadow_branch[TABLE_DEPTH-1], shadow_upper[TABLE_DEPTH-1]);
    ask_rollback(shadow_branch[TABLE_DEPTH-1], shadow_upper[TABLE_DEPTH-1] + 1);
    repeat (12) aimed_query();
    clear_table();
  endtask

  task automatic test_random_mix(input int n_items);
    logic [SEQ_FIELD_W-1:0] lo, up;
    int r;
    for (int i = 0; i < n_items; i++) begin
      if (i % 50 == 0) no_gaps = ($urandom_range(0, 2) == 0);
      r = $urandom_range(0, 99);
      if (r < 42) begin
        random_interval(lo, up);
        if ($urandom_range(0, 99) < 85) begin
          add_interval(pick_branch(), lo, up);
        end else begin
          case ($urandom_range(0, 3))
            0: add_interval(pick_branch(), lo, '0);
            1: add_interval(pick_branch(), '0, up);
            2: add_interval(pick_branch(), up, up);
            default: add_interval(pick_branch(), up, lo);
          endcase
        end
      end else if (r < 95) begin
        aimed_query();
      end else if (r < 98) begin
        clear_table();
      end else begin
        send_item(ACT_SPARE, BRANCH_W'($urandom), rand_seq(), rand_seq(), rand_seq());
      end
    end
    no_gaps = 1'b0;
  endtask

  always @(posedge clk) begin : check_answers
    answer_t exp_ans;
    if (rst_n && out_valid) begin
      if (pending_answers.size() == 0) begin
        note_mismatch("result beat with none pending", 0, out_status);
      end else begin
        exp_ans = pending_answers.pop_front();
        if (out_status !== exp_ans.status)
          note_mismatch("status", exp_ans.status, out_status);
        if (out_rolled_back !== exp_ans.rolled_back)
          note_mismatch("rolled_back", exp_ans.rolled_back, out_rolled_back);
      end
    end
  end

  initial begin
    int waited;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_and_invalid();
    test_interval_bounds();
    test_fill_to_capacity();
    test_random_mix(370);
    start <= 1'b0;
    waited = 0;
    while (pending_answers.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_answers.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

endmodule

/* filelist.f */
design/bimt_pkg.sv
design/bimt_front.sv
design/bimt_queue.sv
design/bimt_back.sv
design/branch_interval_membership_table.sv
dv/branch_interval_membership_table_tb.sv
